### rtl/tspa_pkg.sv
`timescale 1ns / 1ps

package tspa_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NOTE_BITS_DEF   = 16;

    localparam int NUM_GROUPS    = 5;
    localparam int GROUP_BITS    = $clog2(NUM_GROUPS);
    localparam int NUM_IN        = 17;
    localparam int LANE_BITS     = $clog2(NUM_IN);
    localparam int IDX_RST_NOTE  = 15;
    localparam int IDX_RST_FLAGS = 16;
    localparam int SLOT_BITS     = 16;
    localparam int GROUP_FIELD_BITS = 3 * SLOT_BITS;

    localparam int SCALE_BITS = 5;
    localparam int RANGE_BITS = 4;
    localparam int SPAN_BITS  = SCALE_BITS + RANGE_BITS;
    localparam int PULSE_BITS = 16;
    localparam int FRAC_BITS  = 12;
    localparam int OUT_BITS   = 16;
    localparam int OUT_MAX    = 32767;
    localparam int OUT_MIN_MAG = 32768;
    localparam int WIDE_BITS  = 33;

    localparam int SCALE_MIN = 4;
    localparam int SCALE_MAX = 24;
    localparam int RANGE_MIN = 2;
    localparam int RANGE_MAX = 12;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_NOTES_PER_OCTAVE = 2'd0;
    localparam cfg_index_t CFG_RANGE_HALF_VOLTS = 2'd1;
    localparam cfg_index_t CFG_EDGE_KILL        = 2'd2;
    localparam cfg_index_t CFG_PULSE_TICKS      = 2'd3;

    localparam logic [SCALE_BITS-1:0] NOTES_RESET = 5'd12;
    localparam logic [RANGE_BITS-1:0] RANGE_RESET = 4'd4;
    localparam logic [PULSE_BITS-1:0] PULSE_RESET = 16'd48;

    typedef struct packed {
        logic [GROUP_FIELD_BITS-1:0] steps1_samples;
        logic [GROUP_FIELD_BITS-1:0] steps2_samples;
        logic [GROUP_FIELD_BITS-1:0] steps5_samples;
        logic [GROUP_FIELD_BITS-1:0] steps7_samples;
        logic [GROUP_FIELD_BITS-1:0] steps12_samples;
        logic signed [SLOT_BITS-1:0] reset_note_sample;
        logic signed [SLOT_BITS-1:0] reset_flags_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] pitch_volts_q12;
        logic signed [OUT_BITS-1:0] note_half_steps;
        logic                       trigger_pulse;
        logic                       edge_pulse;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic msb;
        logic commit;
    } rise_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_RISE,
        S_PREP,
        S_GROUP,
        S_EDGE,
        S_DSTART,
        S_DIV,
        S_DONE
    } state_t;

    function automatic logic [3:0] interval_step(input logic [GROUP_BITS-1:0] g);
        logic [3:0] step;
        unique case (g)
            3'd0:    step = 4'd1;
            3'd1:    step = 4'd2;
            3'd2:    step = 4'd5;
            3'd3:    step = 4'd7;
            3'd4:    step = 4'd12;
            default: step = 4'd0;
        endcase
        return step;
    endfunction

endpackage

### rtl/tspa_rise.sv
`timescale 1ns / 1ps

module tspa_rise #(
    parameter int SAMPLE_BITS = tspa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  tspa_pkg::rise_ctrl_t                         ctrl,
    input  logic [tspa_pkg::NUM_IN-1:0][SAMPLE_BITS-1:0] samples,
    output logic [tspa_pkg::NUM_IN-1:0]                  fired
);

    localparam int N = tspa_pkg::NUM_IN;

    logic [N-1:0][SAMPLE_BITS-1:0] cur_reg;
    logic [N-1:0][SAMPLE_BITS-1:0] prev_reg;
    logic [N-1:0][SAMPLE_BITS-1:0] prev_next;
    logic [N-1:0]                  gt_reg;
    logic [N-1:0]                  lt_reg;
    logic [N-1:0]                  gt_next;
    logic [N-1:0]                  lt_next;
    logic [N-1:0]                  latch_reg;
    logic [N-1:0]                  fired_reg;

    // lsb-first serial compare, old sample rotates out as the new one rotates in
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            prev_next[i] = {cur_reg[i][0], prev_reg[i][SAMPLE_BITS-1:1]};
            gt_next[i]   = gt_reg[i];
            lt_next[i]   = lt_reg[i];
            if (cur_reg[i][0] != prev_reg[i][0])
            begin
                gt_next[i] = ctrl.msb ? prev_reg[i][0] : cur_reg[i][0];
                lt_next[i] = ctrl.msb ? cur_reg[i][0] : prev_reg[i][0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cur_reg <= samples;
            gt_reg  <= '0;
            lt_reg  <= '0;
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < N; i++)
            begin
                cur_reg[i] <= {1'b0, cur_reg[i][SAMPLE_BITS-1:1]};
            end
            gt_reg <= gt_next;
            lt_reg <= lt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            latch_reg <= '0;
            fired_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                prev_reg <= prev_next;
            end
            if (ctrl.commit)
            begin
                fired_reg <= gt_reg & ~latch_reg;
                latch_reg <= gt_reg | (latch_reg & ~lt_reg);
            end
        end
    end

    assign fired = fired_reg;

endmodule

### rtl/tspa_div.sv
`timescale 1ns / 1ps

module tspa_div #(
    parameter int WIDTH = tspa_pkg::NOTE_BITS_DEF + tspa_pkg::FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [WIDTH-1:0]                dividend,
    input  logic [tspa_pkg::SCALE_BITS-1:0] divisor,
    output logic                            done,
    output logic [WIDTH-1:0]                quotient
);

    localparam int SB    = tspa_pkg::SCALE_BITS;
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg;
    logic [SB-1:0]    rem_reg;
    logic [SB-1:0]    div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SB:0]      trial;
    logic [SB:0]      diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[WIDTH-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WIDTH-2:0], ge};
            rem_reg <= ge ? diff[SB-1:0] : trial[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(WIDTH);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/trigger_step_pitch_accumulator_unit.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------------
// in      | input     | in_valid, in_stall | in_data (17 samples in 7 fields)
// out     | output    | out_valid,out_stall| out_data (volts, note, pulses)
// cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// a request passes the bit-serial rise compare over SAMPLE_BITS sample bits, then
// the group steps, then the volts divider, one quotient bit a cycle over
// NOTE_BITS + 12 bits, and leaves once the output register is free
// rst_n clears sample history, latches, pulse counters and note, sets all flags
// and returns config to its defaults
// a new request is taken only in idle; the output register holds a finished
// result under out_stall while the next request is already being worked

module trigger_step_pitch_accumulator_unit #(
    parameter int SAMPLE_BITS = tspa_pkg::SAMPLE_BITS_DEF,
    parameter int NOTE_BITS   = tspa_pkg::NOTE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tspa_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tspa_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [tspa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tspa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NB    = NOTE_BITS;
    localparam int NG    = tspa_pkg::NUM_GROUPS;
    localparam int GB    = tspa_pkg::GROUP_BITS;
    localparam int DW    = NOTE_BITS + tspa_pkg::FRAC_BITS;
    localparam int BC_W  = $clog2(SAMPLE_BITS);
    localparam int SCB   = tspa_pkg::SCALE_BITS;
    localparam int RB    = tspa_pkg::RANGE_BITS;
    localparam int SPB   = tspa_pkg::SPAN_BITS;
    localparam int PB    = tspa_pkg::PULSE_BITS;
    localparam int OB    = tspa_pkg::OUT_BITS;
    localparam int WB    = tspa_pkg::WIDE_BITS;

    function automatic logic signed [NB-1:0] sat_note(input logic [NB+1:0] v);
        logic signed [NB-1:0] r;
        if (v[NB+1:NB-1] == 3'b000 || v[NB+1:NB-1] == 3'b111)
        begin
            r = v[NB-1:0];
        end
        else if (v[NB+1])
        begin
            r = {1'b1, {(NB-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(NB-1){1'b1}}};
        end
        return r;
    endfunction

    tspa_pkg::state_t state_reg;
    tspa_pkg::state_t state_next;

    logic [SCB-1:0] notes_reg;
    logic [RB-1:0]  range_reg;
    logic           kill_reg;
    logic [PB-1:0]  pulse_reg;

    logic [SCB-1:0] scale;
    logic [RB-1:0]  rhv;
    logic [SPB-1:0] span;

    logic [NG-1:0][tspa_pkg::GROUP_FIELD_BITS-1:0]   grp_fields;
    logic [tspa_pkg::NUM_IN-1:0][SAMPLE_BITS-1:0]    samples;
    tspa_pkg::rise_ctrl_t                            rise_ctrl;
    logic [tspa_pkg::NUM_IN-1:0]                     fired;

    logic [BC_W-1:0]       bit_cnt_reg;
    logic [GB-1:0]         grp_reg;
    logic [NG-1:0]         flags_reg;
    logic signed [NB-1:0]  note_reg;
    logic                  any_reg;
    logic [PB-1:0]         trig_cnt_reg;
    logic [PB-1:0]         edge_cnt_reg;
    logic                  neg_reg;

    logic                  accept;
    logic                  cmp_last;
    logic                  out_free;
    logic                  out_load;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tspa_pkg::out_item_t   out_data_reg;
    tspa_pkg::out_item_t   out_item;

    logic [tspa_pkg::LANE_BITS-1:0] lane_base;
    logic [2:0]                     grp_fire;
    logic                           grp_flag;
    logic [3:0]                     interval;
    logic signed [2:0]              alt;
    logic signed [2:0]              mult;
    logic signed [7:0]              delta;
    logic [NB+1:0]                  grp_sum;

    logic signed [NB+1:0] note4;
    logic signed [NB+1:0] span_ext;
    logic [NB+1:0]        half_ext;
    logic [NB+1:0]        note_ext;
    logic [NB+1:0]        wrap_sum;
    logic                 above;
    logic                 below;
    logic                 edge_hit;
    logic signed [NB-1:0] note_edge;
    logic [PB-1:0]        trig_load;
    logic [PB-1:0]        edge_load;
    logic [PB-1:0]        trig_after;
    logic [PB-1:0]        edge_after;

    logic                  div_start;
    logic                  div_done;
    logic [NB-1:0]         note_mag;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_quo;
    logic signed [OB-1:0]  pitch;
    logic signed [WB-1:0]  note_wide;
    logic signed [OB-1:0]  note_out;

    // clamped configuration
    always_comb
    begin
        if (notes_reg < SCB'(tspa_pkg::SCALE_MIN))
        begin
            scale = SCB'(tspa_pkg::SCALE_MIN);
        end
        else if (notes_reg > SCB'(tspa_pkg::SCALE_MAX))
        begin
            scale = SCB'(tspa_pkg::SCALE_MAX);
        end
        else
        begin
            scale = notes_reg;
        end
        if (range_reg < RB'(tspa_pkg::RANGE_MIN))
        begin
            rhv = RB'(tspa_pkg::RANGE_MIN);
        end
        else if (range_reg > RB'(tspa_pkg::RANGE_MAX))
        begin
            rhv = RB'(tspa_pkg::RANGE_MAX);
        end
        else
        begin
            rhv = range_reg;
        end
        span = {{SCB{1'b0}}, rhv} * {{RB{1'b0}}, scale};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notes_reg <= tspa_pkg::NOTES_RESET;
            range_reg <= tspa_pkg::RANGE_RESET;
            kill_reg  <= 1'b0;
            pulse_reg <= tspa_pkg::PULSE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tspa_pkg::CFG_NOTES_PER_OCTAVE: notes_reg <= cfg_data[SCB-1:0];
                tspa_pkg::CFG_RANGE_HALF_VOLTS: range_reg <= cfg_data[RB-1:0];
                tspa_pkg::CFG_EDGE_KILL:        kill_reg  <= cfg_data[0];
                tspa_pkg::CFG_PULSE_TICKS:      pulse_reg <= cfg_data[PB-1:0];
            endcase
        end
    end

    // sample lanes: three per group, then note reset and flag reset
    assign grp_fields = {in_data.steps12_samples, in_data.steps7_samples,
                         in_data.steps5_samples, in_data.steps2_samples,
                         in_data.steps1_samples};

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            assign samples[g*3+k] = grp_fields[g][tspa_pkg::SLOT_BITS*k +: SAMPLE_BITS];
        end
    end
    assign samples[tspa_pkg::IDX_RST_NOTE]  = in_data.reset_note_sample[SAMPLE_BITS-1:0];
    assign samples[tspa_pkg::IDX_RST_FLAGS] = in_data.reset_flags_sample[SAMPLE_BITS-1:0];

    tspa_rise #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_rise (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (rise_ctrl),
        .samples(samples),
        .fired  (fired)
    );

    // one interval group per cycle
    always_comb
    begin
        lane_base = tspa_pkg::LANE_BITS'(grp_reg) * tspa_pkg::LANE_BITS'(3);
        grp_fire  = fired[lane_base +: 3];
        grp_flag  = flags_reg[grp_reg];
        interval  = tspa_pkg::interval_step(grp_reg);
        if (!grp_fire[2])
        begin
            alt = 3'sd0;
        end
        else if (grp_flag)
        begin
            alt = 3'sd1;
        end
        else
        begin
            alt = -3'sd1;
        end
        mult    = $signed({2'b00, grp_fire[0]}) - $signed({2'b00, grp_fire[1]}) + alt;
        delta   = $signed({{5{mult[2]}}, mult}) * $signed({4'b0000, interval});
        grp_sum = {{2{note_reg[NB-1]}}, note_reg} + {{(NB-6){delta[7]}}, delta};
    end

    // window edge and pulse counters
    always_comb
    begin
        note4    = $signed({note_reg, 2'b00});
        span_ext = $signed({{(NB+2-SPB){1'b0}}, span});
        above    = note4 > span_ext;
        below    = note4 < -span_ext;
        edge_hit = above || below;
        half_ext = {{(NB+3-SPB){1'b0}}, span[SPB-1:1]};
        note_ext = {{2{note_reg[NB-1]}}, note_reg};
        wrap_sum = above ? (note_ext - half_ext) : (note_ext + half_ext);
        if (!edge_hit)
        begin
            note_edge = note_reg;
        end
        else if (kill_reg)
        begin
            note_edge = '0;
        end
        else
        begin
            note_edge = sat_note(wrap_sum);
        end
        trig_load  = any_reg ? pulse_reg : trig_cnt_reg;
        edge_load  = edge_hit ? pulse_reg : edge_cnt_reg;
        trig_after = (trig_load != '0) ? (trig_load - PB'(1)) : '0;
        edge_after = (edge_load != '0) ? (edge_load - PB'(1)) : '0;
    end

    // volts: |note| * 4096 + scale/2, divided by scale
    always_comb
    begin
        note_mag     = note_reg[NB-1] ? (~note_reg + NB'(1)) : note_reg;
        div_dividend = {note_mag, {tspa_pkg::FRAC_BITS{1'b0}}} + DW'(scale[SCB-1:1]);
    end

    tspa_div #(
        .WIDTH(DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (scale),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_comb
    begin
        if (!neg_reg)
        begin
            pitch = (div_quo > DW'(tspa_pkg::OUT_MAX)) ? {1'b0, {(OB-1){1'b1}}}
                                                        : $signed(div_quo[OB-1:0]);
        end
        else
        begin
            pitch = (div_quo > DW'(tspa_pkg::OUT_MIN_MAG)) ? {1'b1, {(OB-1){1'b0}}}
                                                            : $signed(~div_quo[OB-1:0]
                                                                      + OB'(1));
        end
        note_wide = WB'(note_reg);
        if (note_wide > WB'(tspa_pkg::OUT_MAX))
        begin
            note_out = {1'b0, {(OB-1){1'b1}}};
        end
        else if (note_wide < -WB'(tspa_pkg::OUT_MIN_MAG))
        begin
            note_out = {1'b1, {(OB-1){1'b0}}};
        end
        else
        begin
            note_out = note_wide[OB-1:0];
        end
        out_item.pitch_volts_q12 = pitch;
        out_item.note_half_steps = note_out;
        out_item.trigger_pulse   = trig_cnt_reg != '0;
        out_item.edge_pulse      = edge_cnt_reg != '0;
    end

    assign cmp_last = bit_cnt_reg == BC_W'(SAMPLE_BITS - 1);
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tspa_pkg::S_IDLE:   if (in_valid) state_next = tspa_pkg::S_CMP;
            tspa_pkg::S_CMP:    if (cmp_last) state_next = tspa_pkg::S_RISE;
            tspa_pkg::S_RISE:   state_next = tspa_pkg::S_PREP;
            tspa_pkg::S_PREP:   state_next = tspa_pkg::S_GROUP;
            tspa_pkg::S_GROUP:  if (grp_reg == GB'(NG - 1)) state_next = tspa_pkg::S_EDGE;
            tspa_pkg::S_EDGE:   state_next = tspa_pkg::S_DSTART;
            tspa_pkg::S_DSTART: state_next = tspa_pkg::S_DIV;
            tspa_pkg::S_DIV:    if (div_done) state_next = tspa_pkg::S_DONE;
            tspa_pkg::S_DONE:   if (out_free) state_next = tspa_pkg::S_IDLE;
            default:            state_next = tspa_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall         = state_reg != tspa_pkg::S_IDLE;
        accept           = (state_reg == tspa_pkg::S_IDLE) && in_valid;
        rise_ctrl.load   = accept;
        rise_ctrl.shift  = state_reg == tspa_pkg::S_CMP;
        rise_ctrl.msb    = (state_reg == tspa_pkg::S_CMP) && cmp_last;
        rise_ctrl.commit = state_reg == tspa_pkg::S_RISE;
        div_start        = state_reg == tspa_pkg::S_DSTART;
        out_load         = (state_reg == tspa_pkg::S_DONE) && out_free;
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tspa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            grp_reg       <= '0;
            flags_reg     <= '1;
            note_reg      <= '0;
            any_reg       <= 1'b0;
            trig_cnt_reg  <= '0;
            edge_cnt_reg  <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                tspa_pkg::S_IDLE:
                begin
                    bit_cnt_reg <= '0;
                end
                tspa_pkg::S_CMP:
                begin
                    bit_cnt_reg <= bit_cnt_reg + BC_W'(1);
                end
                tspa_pkg::S_PREP:
                begin
                    grp_reg <= '0;
                    any_reg <= 1'b0;
                    if (fired[tspa_pkg::IDX_RST_FLAGS])
                    begin
                        flags_reg <= '1;
                    end
                    if (fired[tspa_pkg::IDX_RST_NOTE])
                    begin
                        note_reg <= '0;
                    end
                end
                tspa_pkg::S_GROUP:
                begin
                    grp_reg  <= grp_reg + GB'(1);
                    note_reg <= sat_note(grp_sum);
                    any_reg  <= any_reg || (grp_fire != 3'b000);
                    if (grp_fire[2])
                    begin
                        flags_reg[grp_reg] <= !grp_flag;
                    end
                end
                tspa_pkg::S_EDGE:
                begin
                    note_reg     <= note_edge;
                    trig_cnt_reg <= trig_after;
                    edge_cnt_reg <= edge_after;
                end
                tspa_pkg::S_DSTART:
                begin
                    neg_reg <= note_reg[NB-1];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tspa_pkg::S_DONE))
        else $error("result appeared outside the done step");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == tspa_pkg::S_DIV)
        else $error("divider finished outside the divide step");

    a_kill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tspa_pkg::S_DSTART) && kill_reg && $past(kill_reg)
            && $stable(range_reg) && $stable(notes_reg)
        |-> (note4 <= span_ext) && (note4 >= -span_ext))
        else $error("note left the window with edge kill set");

endmodule

### dv/trigger_step_pitch_accumulator_unit_test.sv
`timescale 1ns / 1ps

module trigger_step_pitch_accumulator_unit_test;

    localparam int NG   = tspa_pkg::NUM_GROUPS;
    localparam int NI   = tspa_pkg::NUM_IN;
    localparam int SLOT = tspa_pkg::SLOT_BITS;
    localparam int GFB  = tspa_pkg::GROUP_FIELD_BITS;
    localparam int DB   = tspa_pkg::CFG_DATA_BITS;
    localparam int I_RN = tspa_pkg::IDX_RST_NOTE;
    localparam int I_RF = tspa_pkg::IDX_RST_FLAGS;

    localparam int INTERVAL[NG] = '{1, 2, 5, 7, 12};
    localparam int PHASES = 8;
    localparam int TICKS_PER_PHASE = 216;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 80;

    typedef enum int {HOLD, NUDGE_UP, NUDGE_DOWN, JUMP} lane_move_t;

    class pitch_scoreboard;
        logic signed [SLOT-1:0] prev_smp [NI];
        bit latch [NI];
        bit alt_up [NG];
        int note;
        int trig_cnt;
        int edge_cnt;
        int npo;
        int rng;
        int kill;
        int pulse;
        tspa_pkg::out_item_t pitch_results_due [$];
        int errors;

        function new();
            for (int i = 0; i < NI; i++)
            begin
                prev_smp[i] = '0;
                latch[i] = 1'b0;
            end
            for (int g = 0; g < NG; g++)
                alt_up[g] = 1'b1;
            note = 0;
            trig_cnt = 0;
            edge_cnt = 0;
            npo = int'(tspa_pkg::NOTES_RESET);
            rng = int'(tspa_pkg::RANGE_RESET);
            kill = 0;
            pulse = int'(tspa_pkg::PULSE_RESET);
            errors = 0;
        endfunction

        function void write_reg(tspa_pkg::cfg_index_t idx, logic [DB-1:0] val);
            case (idx)
                tspa_pkg::CFG_NOTES_PER_OCTAVE: npo = int'(val[tspa_pkg::SCALE_BITS-1:0]);
                tspa_pkg::CFG_RANGE_HALF_VOLTS: rng = int'(val[tspa_pkg::RANGE_BITS-1:0]);
                tspa_pkg::CFG_EDGE_KILL:        kill = int'(val[0]);
                tspa_pkg::CFG_PULSE_TICKS:      pulse = int'(val[tspa_pkg::PULSE_BITS-1:0]);
                default:                        ;
            endcase
        endfunction

        function int sat16(int v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function int pending();
            return pitch_results_due.size();
        endfunction

        function void accumulate_tick(tspa_pkg::in_item_t req);
            logic [GFB-1:0] grp [NG];
            logic signed [SLOT-1:0] cur [NI];
            bit fired [NI];
            bit any_step;
            bit up;
            bit dn;
            bit alt;
            int scale;
            int rhv;
            int span;
            int mult;
            int num;
            int mag;
            int q;
            tspa_pkg::out_item_t due;
            grp[0] = req.steps1_samples;
            grp[1] = req.steps2_samples;
            grp[2] = req.steps5_samples;
            grp[3] = req.steps7_samples;
            grp[4] = req.steps12_samples;
            for (int g = 0; g < NG; g++)
                for (int i = 0; i < 3; i++)
                    cur[g * 3 + i] = grp[g][SLOT * i +: SLOT];
            cur[I_RN] = req.reset_note_sample;
            cur[I_RF] = req.reset_flags_sample;
            scale = npo < tspa_pkg::SCALE_MIN ? tspa_pkg::SCALE_MIN
                  : (npo > tspa_pkg::SCALE_MAX ? tspa_pkg::SCALE_MAX : npo);
            rhv = rng < tspa_pkg::RANGE_MIN ? tspa_pkg::RANGE_MIN
                : (rng > tspa_pkg::RANGE_MAX ? tspa_pkg::RANGE_MAX : rng);
            span = rhv * scale;

            for (int i = 0; i < NI; i++)
            begin
                fired[i] = 1'b0;
                if (cur[i] > prev_smp[i] && !latch[i])
                begin
                    fired[i] = 1'b1;
                    latch[i] = 1'b1;
                end
                if (cur[i] < prev_smp[i])
                    latch[i] = 1'b0;
                prev_smp[i] = cur[i];
            end

            if (fired[I_RF])
                for (int g = 0; g < NG; g++)
                    alt_up[g] = 1'b1;
            if (fired[I_RN])
                note = 0;

            any_step = 1'b0;
            for (int g = 0; g < NG; g++)
            begin
                up = fired[g * 3];
                dn = fired[g * 3 + 1];
                alt = fired[g * 3 + 2];
                mult = int'(up) - int'(dn);
                if (alt)
                    mult += alt_up[g] ? 1 : -1;
                note = sat16(note + mult * INTERVAL[g]);
                if (up || dn || alt)
                    any_step = 1'b1;
                if (alt)
                    alt_up[g] = !alt_up[g];
            end

            if (any_step)
                trig_cnt = pulse;

            if (kill == 0)
            begin
                if (4 * note > span)
                begin
                    note = sat16(note - span / 2);
                    edge_cnt = pulse;
                end
                else if (4 * note < -span)
                begin
                    note = sat16(note + span / 2);
                    edge_cnt = pulse;
                end
            end
            else if (4 * note > span || 4 * note < -span)
            begin
                note = 0;
                edge_cnt = pulse;
            end

            if (edge_cnt > 0)
                edge_cnt--;
            if (trig_cnt > 0)
                trig_cnt--;

            num = note * 4096;
            mag = num < 0 ? -num : num;
            q = (mag + scale / 2) / scale;
            if (num < 0)
                q = -q;
            q = sat16(q);

            due.pitch_volts_q12 = 16'(q);
            due.note_half_steps = 16'(note);
            due.trigger_pulse = trig_cnt > 0;
            due.edge_pulse = edge_cnt > 0;
            pitch_results_due.push_back(due);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_pitch(tspa_pkg::out_item_t got);
            tspa_pkg::out_item_t want;
            if (pitch_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, volts %0d note %0d", $time,
                         got.pitch_volts_q12, got.note_half_steps);
                return;
            end
            want = pitch_results_due.pop_front();
            if ($isunknown(got))
            begin
                errors++;
                $display("%0t: result expected %h actual %h", $time, want, got);
                return;
            end
            compare_field("pitch_volts_q12", int'(want.pitch_volts_q12),
                          int'(got.pitch_volts_q12));
            compare_field("note_half_steps", int'(want.note_half_steps),
                          int'(got.note_half_steps));
            compare_field("trigger_pulse", int'(want.trigger_pulse), int'(got.trigger_pulse));
            compare_field("edge_pulse", int'(want.edge_pulse), int'(got.edge_pulse));
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    tspa_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    tspa_pkg::out_item_t out_data;
    logic cfg_write = 1'b0;
    tspa_pkg::cfg_index_t cfg_index = tspa_pkg::CFG_NOTES_PER_OCTAVE;
    logic [DB-1:0] cfg_data = '0;

    pitch_scoreboard sb = new();
    int last_smp [NI];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    trigger_step_pitch_accumulator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // accepted requests feed the predictor, accepted results are checked
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.accumulate_tick(in_data);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                sb.check_pitch(out_data);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("trigger_step_pitch_accumulator_unit_test: errors");
        $finish;
    end

    function automatic tspa_pkg::in_item_t pack_item(input int smp [NI]);
        tspa_pkg::in_item_t it;
        logic [GFB-1:0] grp [NG];
        for (int g = 0; g < NG; g++)
            grp[g] = {16'(smp[g * 3 + 2]), 16'(smp[g * 3 + 1]), 16'(smp[g * 3])};
        it.steps1_samples = grp[0];
        it.steps2_samples = grp[1];
        it.steps5_samples = grp[2];
        it.steps7_samples = grp[3];
        it.steps12_samples = grp[4];
        it.reset_note_sample = 16'(smp[I_RN]);
        it.reset_flags_sample = 16'(smp[I_RF]);
        return it;
    endfunction

    // mostly gate-like toggling, some ramps and holds, a little noise
    function automatic tspa_pkg::in_item_t random_tick();
        int kind;
        int v;
        lane_move_t move;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < NI; i++)
        begin
            v = last_smp[i];
            if (kind < 70)
            begin
                if ($urandom_range(0, 99) < ((i < I_RN) ? 30 : 6))
                    v = (v > 0) ? -int'($urandom_range(0, 32768))
                                : int'($urandom_range(1, 32767));
            end
            else if (kind < 90)
            begin
                move = lane_move_t'($urandom_range(0, 3));
                case (move)
                    NUDGE_UP:   v = v + int'($urandom_range(1, 4));
                    NUDGE_DOWN: v = v - int'($urandom_range(1, 4));
                    JUMP:       v = int'($signed(16'($urandom)));
                    default:    ;
                endcase
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
            end
            else
                v = int'($signed(16'($urandom)));
            last_smp[i] = v;
        end
        return pack_item(last_smp);
    endfunction

    task automatic send_tick(input tspa_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_levels(input int level);
        for (int i = 0; i < NI; i++)
            last_smp[i] = level;
        send_tick(pack_item(last_smp));
    endtask

    task automatic program_regs(input logic [DB-1:0] npo,
                                input logic [DB-1:0] rng,
                                input logic [DB-1:0] kill,
                                input logic [DB-1:0] pulse);
        tspa_pkg::cfg_index_t idx [4];
        logic [DB-1:0] vals [4];
        idx = '{tspa_pkg::CFG_NOTES_PER_OCTAVE, tspa_pkg::CFG_RANGE_HALF_VOLTS,
                tspa_pkg::CFG_EDGE_KILL, tspa_pkg::CFG_PULSE_TICKS};
        vals = '{npo, rng, kill, pulse};
        for (int r = 0; r < 4; r++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[r];
            cfg_data <= vals[r];
            @(posedge clk);
            sb.write_reg(idx[r], vals[r]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int send_pcts [4];
        int stall_pcts [4];
        int mode;
        logic [DB-1:0] npo;
        logic [DB-1:0] rng;
        logic [DB-1:0] kill;
        logic [DB-1:0] pulse;
        send_pcts = '{0, 88, 0, 15};
        stall_pcts = '{0, 0, 88, 15};
        for (int i = 0; i < NI; i++)
            last_smp[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // each lane rises alone, then holds, falls, all rise, latched ramp
        send_levels(-32768);
        for (int k = 0; k < NI; k++)
        begin
            last_smp[k] = 32767;
            send_tick(pack_item(last_smp));
        end
        send_levels(32767);
        send_levels(-32768);
        send_levels(32767);
        send_levels(0);
        send_levels(1);
        send_levels(2);

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            drain();
            send_idle_pct = 0;
            stall_pct = 0;
            case (p)
                0:
                begin
                    npo = 4; rng = 2; kill = 0; pulse = 1;
                end
                1:
                begin
                    npo = 24; rng = 12; kill = 1; pulse = 65535;
                end
                2:
                begin
                    npo = 0; rng = 15; kill = 0; pulse = 0;
                end
                3:
                begin
                    npo = 31; rng = 0; kill = 1; pulse = 3;
                end
                default:
                begin
                    npo = DB'($urandom_range(0, 31));
                    rng = DB'($urandom_range(0, 15));
                    kill = DB'($urandom_range(0, 1));
                    pulse = ($urandom_range(0, 3) == 0) ? DB'($urandom_range(0, 65535))
                                                        : DB'($urandom_range(2, 40));
                end
            endcase
            program_regs(npo, rng, kill, pulse);
            mode = p % 4;
            send_idle_pct = send_pcts[mode];
            stall_pct = stall_pcts[mode];
            for (int n = 0; n < TICKS_PER_PHASE; n++)
                send_tick(random_tick());
        end

        in_valid <= 1'b0;
        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("trigger_step_pitch_accumulator_unit_test: clean");
        else
            $display("trigger_step_pitch_accumulator_unit_test: errors");
        $finish;
    end

endmodule

### files.f
rtl/tspa_pkg.sv
rtl/tspa_rise.sv
rtl/tspa_div.sv
rtl/trigger_step_pitch_accumulator_unit.sv
dv/trigger_step_pitch_accumulator_unit_test.sv
